// ===== rtl/core/ple_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes of the positional list engine: operation and status
// codes, the item and result beat layouts, and the controller/datapath links.
// ----------------------------------------------------------------------------
package ple_pkg;

	// Fixed widths of the beat fields.
	localparam int FUNC_W   = 2;
	localparam int POS_W    = 5;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		OP_LOCATE = 2'd0,
		OP_GET    = 2'd1,
		OP_INSERT = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		op_t                func;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] read_value;
		logic [POS_W-1:0]   found_pos;
		logic [POS_W-1:0]   count;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // latch the incoming beat and set up the walk pointer
		logic reject;      // incoming beat fails its checks: report its status now
		logic issue;       // read the entry under the walk pointer and step it
		logic wr_shift;    // write back the entry read in the previous cycle
		logic wr_ins_val;  // write the insert value at its position
		logic capture;     // keep the entry being deleted
		logic finish;      // register a successful result and update the count
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  in_func;     // operation of the incoming beat
		logic in_err;      // incoming beat fails its checks
		op_t  op;          // operation being worked on
		logic more;        // entries remain to be read in this walk
		logic pend;        // a read issued last cycle has its data ready
		logic hit;         // that data matches the locate value
		logic last;        // that data is the last entry of the list
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/ple_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ctrl
// Controller of the positional list engine: sequences each operation through
// the list walk and drives the datapath by commands.
// ----------------------------------------------------------------------------
module ple_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ple_pkg::sts_t sts,
	output ple_pkg::cmd_t      cmd,
	output logic               busy
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOC  = 6'b000010,
		S_RD1  = 6'b000100,
		S_RD2  = 6'b001000,
		S_DEL  = 6'b010000,
		S_INS  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (sts.in_err) begin
						cmd.reject = 1'b1;
					end else begin
						case (sts.in_func)
							ple_pkg::OP_LOCATE: state_d = S_LOC;
							ple_pkg::OP_INSERT: state_d = S_INS;
							default:            state_d = S_RD1;
						endcase
					end
				end
			end
			S_LOC: begin
				cmd.issue = sts.more;
				if (sts.hit || (sts.pend && sts.last)) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_RD1: begin
				cmd.issue = 1'b1;
				state_d   = S_RD2;
			end
			S_RD2: begin
				if (sts.op == ple_pkg::OP_GET) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.capture = 1'b1;
					state_d     = S_DEL;
				end
			end
			S_DEL: begin
				cmd.issue    = sts.more;
				cmd.wr_shift = sts.pend;
				if (!sts.more && !sts.pend) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_INS: begin
				cmd.issue    = sts.more;
				cmd.wr_shift = sts.pend;
				if (!sts.more && !sts.pend) begin
					cmd.wr_ins_val = 1'b1;
					cmd.finish     = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/ple_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ple_dpath
// Datapath of the positional list engine: entry memory, entry count, walk
// pointer with a one-stage read pipeline, beat checks and result register.
// ----------------------------------------------------------------------------
module ple_dpath #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ple_pkg::item_t  item,
	input  wire ple_pkg::cmd_t   cmd,
	output ple_pkg::sts_t        sts,
	output ple_pkg::result_t     result,
	output logic                 done
);

	localparam int IW  = $clog2(CAPACITY + 1);
	localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW  = ple_pkg::POS_W;
	localparam int CW  = ((IW > PW) ? IW : PW) + 1;
	localparam int VW  = VALUE_WIDTH;
	localparam int OVW = ple_pkg::VALUE_W;

	logic [VW-1:0]   mem [CAPACITY];

	logic [IW-1:0]   cnt_q;
	logic [IW-1:0]   ptr_q;
	ple_pkg::op_t    op_q;
	logic [PW-1:0]   pos_q;
	logic [VW-1:0]   val_q;
	logic [VW-1:0]   got_q;
	logic [VW-1:0]   rdata_s1;
	logic [IW-1:0]   idx_s1;
	logic            vld_s1;
	ple_pkg::result_t res_q;
	logic            done_q;

	logic [IW-1:0]   pos_iw;
	logic [CW-1:0]   in_pos_w;
	logic [CW-1:0]   cnt_w;
	logic            is_empty;
	logic            is_full;
	ple_pkg::status_t in_status;
	logic            is_ins;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic [VW-1:0]   wr_data;
	logic            wr_en;
	logic [IW-1:0]   cnt_new;

	// Checks on the incoming beat against the current count.
	assign in_pos_w = CW'(item.pos);
	assign cnt_w    = CW'(cnt_q);
	assign is_empty = (cnt_q == '0);
	assign is_full  = (cnt_q == IW'(CAPACITY));

	always_comb begin
		in_status = ple_pkg::ST_OK;
		case (item.func)
			ple_pkg::OP_LOCATE: begin
				if (is_empty) begin
					in_status = ple_pkg::ST_EMPTY;
				end
			end
			ple_pkg::OP_INSERT: begin
				if ((item.pos == '0) || (in_pos_w > cnt_w + CW'(1))) begin
					in_status = ple_pkg::ST_BADPOS;
				end else if (is_full) begin
					in_status = ple_pkg::ST_FULL;
				end
			end
			default: begin
				if (is_empty) begin
					in_status = ple_pkg::ST_EMPTY;
				end else if ((item.pos == '0) || (in_pos_w > cnt_w)) begin
					in_status = ple_pkg::ST_BADPOS;
				end
			end
		endcase
	end

	// Walk control. Insert walks down from the top entry; the others walk up.
	assign pos_iw = IW'(pos_q);
	assign is_ins = (op_q == ple_pkg::OP_INSERT);

	always_comb begin
		sts         = '0;
		sts.in_func = item.func;
		sts.in_err  = (in_status != ple_pkg::ST_OK);
		sts.op      = op_q;
		sts.more    = is_ins ? (ptr_q >= pos_iw) : (ptr_q < cnt_q);
		sts.pend    = vld_s1;
		sts.hit     = vld_s1 && (rdata_s1 == val_q);
		sts.last    = (idx_s1 == cnt_q - IW'(1));
	end

	assign rd_addr = is_ins ? AW'(ptr_q - IW'(1)) : AW'(ptr_q);
	assign wr_en   = cmd.wr_shift || cmd.wr_ins_val;
	assign wr_data = cmd.wr_ins_val ? val_q : rdata_s1;

	always_comb begin
		if (cmd.wr_ins_val) begin
			wr_addr = AW'(pos_iw - IW'(1));
		end else if (is_ins) begin
			wr_addr = AW'(idx_s1);
		end else begin
			wr_addr = AW'(idx_s1 - IW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rdata_s1 <= mem[rd_addr];
			idx_s1   <= ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
		end
	end

	// Beat latch and walk pointer.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= item.func;
			pos_q <= item.pos;
			val_q <= VW'(item.value);
			case (item.func)
				ple_pkg::OP_LOCATE: ptr_q <= '0;
				ple_pkg::OP_INSERT: ptr_q <= cnt_q;
				default:            ptr_q <= IW'(item.pos) - IW'(1);
			endcase
		end else if (cmd.issue) begin
			ptr_q <= is_ins ? (ptr_q - IW'(1)) : (ptr_q + IW'(1));
		end
		if (cmd.capture) begin
			got_q <= rdata_s1;
		end
	end

	// Entry count.
	always_comb begin
		case (op_q)
			ple_pkg::OP_INSERT: cnt_new = cnt_q + IW'(1);
			ple_pkg::OP_DELETE: cnt_new = cnt_q - IW'(1);
			default:            cnt_new = cnt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.finish) begin
			cnt_q <= cnt_new;
		end
	end

	// Result register and strobe.
	always_ff @(posedge clk) begin
		if (cmd.reject) begin
			res_q.status     <= in_status;
			res_q.read_value <= '0;
			res_q.found_pos  <= '0;
			res_q.count      <= PW'(cnt_q);
		end else if (cmd.finish) begin
			res_q.status     <= ple_pkg::ST_OK;
			res_q.count      <= PW'(cnt_new);
			res_q.found_pos  <= ((op_q == ple_pkg::OP_LOCATE) && sts.hit) ?
				PW'(idx_s1 + IW'(1)) : '0;
			case (op_q)
				ple_pkg::OP_GET:    res_q.read_value <= OVW'(rdata_s1);
				ple_pkg::OP_DELETE: res_q.read_value <= OVW'(got_q);
				default:            res_q.read_value <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.reject || cmd.finish;
		end
	end

	assign result = res_q;
	assign done   = done_q;

endmodule
`default_nettype wire

// ===== rtl/core/positional_list_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY values addressed by 1-based position, with
// locate, get, insert and delete operations and one result beat per command.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                     Direction  Transfer
//  --------  ------------------------  ---------  ------------------------------
//  command   start, busy, item         in         beat taken when start && !busy
//  result    done, result              out        beat valid for the single
//                                                 cycle in which done is high
//
// A command that fails its checks (empty list, bad position, full list) gives
// its result beat in the cycle after it is taken, without entering the walk.
// Get reads its entry; locate walks up from the first entry until a match
// or the last entry; insert shifts the entries from the top down to its
// position and then writes its value; delete keeps its entry and shifts
// the ones above it down. The entry memory gives one read and one write
// per cycle while the list is walked or shifted one entry at a time.
// Busy is low again in the cycle that shows the result, so the next command
// can be taken there. Reset clears the count; the entry memory is not cleared,
// as no entry is read before it was written. The receiver cannot stall the
// result, so a beat is shown once and never held.
//
module positional_list_engine #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire ple_pkg::item_t item,
	output logic                busy,
	output logic                done,
	output ple_pkg::result_t    result
);

	// Command and status between the sequencer and the datapath.
	ple_pkg::cmd_t cmd;
	ple_pkg::sts_t sts;

	// The controller owns the operation sequence: it decides when the walk
	// pointer steps, when memory is written and when the result is latched.
	ple_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the entries, the count and the result register. It
	// also checks each incoming command against the count so that failures
	// are answered without entering the walk.
	ple_dpath #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result),
		.done   (done)
	);

endmodule
`default_nettype wire

// ===== tb/sv/tb_positional_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the positional list engine. A shadow copy of the
// list predicts every result beat from the command beats that the block
// takes. Directed commands cover the empty, bad position and full cases.
// Random commands follow: mostly well-formed ones, some noise, and sender
// gaps that change from phase to phase.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;

	localparam int LIST_DEPTH   = 16;
	localparam int PHASE_ITEMS  = 200;
	localparam int MAX_GAP      = 40;
	// Cycles without any beat in either direction before the run is abandoned.
	// The limit lies far above the longest command walk of the full list and
	// the longest sender gap, so this leaves a wide margin.
	localparam int QUIET_LIMIT  = 2000;
	// Cycles to watch for stray result beats once nothing is awaited.
	localparam int TAIL_CYCLES  = 40;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             start  = 1'b0;
	ple_pkg::item_t   item   = '0;
	logic             busy;
	logic             done;
	ple_pkg::result_t result;

	// ------------------------------------------------------------------------
	// Shadow of the list. It applies every accepted command beat to its own
	// copy of the entries and the count, and queues the result beat that the
	// command should produce.
	// ------------------------------------------------------------------------
	class list_shadow;
		logic [ple_pkg::VALUE_W-1:0] slots [LIST_DEPTH];
		int                          fill;
		ple_pkg::result_t            awaited [$];
		int                          mismatches;

		function new();
			fill = 0;
			mismatches = 0;
			foreach (slots[k]) slots[k] = '0;
		endfunction

		function void note_command(ple_pkg::item_t cmd);
			ple_pkg::result_t want;
			int               n;
			int               p;
			int               k;
			n = fill;
			p = int'(cmd.pos);
			want = '0;
			want.status = ple_pkg::ST_OK;
			case (cmd.func)
				ple_pkg::OP_LOCATE: begin
					if (n == 0) begin
						want.status = ple_pkg::ST_EMPTY;
					end else begin
						for (k = 0; k < n; k++) begin
							if (slots[k] == cmd.value) begin
								want.found_pos = ple_pkg::POS_W'(k + 1);
								break;
							end
						end
					end
				end
				ple_pkg::OP_GET: begin
					if (n == 0) begin
						want.status = ple_pkg::ST_EMPTY;
					end else if (p < 1 || p > n) begin
						want.status = ple_pkg::ST_BADPOS;
					end else begin
						want.read_value = slots[p-1];
					end
				end
				ple_pkg::OP_INSERT: begin
					// The position check wins over the full check.
					if (p < 1 || p > n + 1) begin
						want.status = ple_pkg::ST_BADPOS;
					end else if (n >= LIST_DEPTH) begin
						want.status = ple_pkg::ST_FULL;
					end else begin
						for (k = n; k >= p; k--) slots[k] = slots[k-1];
						slots[p-1] = cmd.value;
						fill = n + 1;
					end
				end
				default: begin
					if (n == 0) begin
						want.status = ple_pkg::ST_EMPTY;
					end else if (p < 1 || p > n) begin
						want.status = ple_pkg::ST_BADPOS;
					end else begin
						want.read_value = slots[p-1];
						for (k = p; k < n; k++) slots[k-1] = slots[k];
						slots[n-1] = '0;
						fill = n - 1;
					end
				end
			endcase
			want.count = ple_pkg::POS_W'(fill);
			awaited.push_back(want);
		endfunction

		task report(string msg);
			$display("mismatch at %0t ns: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(ple_pkg::result_t got);
			ple_pkg::result_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result beat %p with no command outstanding", got));
			end else begin
				want = awaited.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.read_value !== want.read_value)
					report($sformatf("read_value %h, want %h", got.read_value,
						want.read_value));
				if (got.found_pos !== want.found_pos)
					report($sformatf("found_pos %0d, want %0d", got.found_pos,
						want.found_pos));
				if (got.count !== want.count)
					report($sformatf("count %0d, want %0d", got.count, want.count));
			end
		endtask
	endclass

	list_shadow shadow = new();
	int         quiet_cycles = 0;
	bit         growing = 1'b1;

	positional_list_engine #(
		.CAPACITY    (LIST_DEPTH),
		.VALUE_WIDTH (ple_pkg::VALUE_W)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------------
	// Monitor. Everything is sampled on the falling edge, away from the rising
	// edge at which the driver and the block change their signals.
	// A command seen with start high and busy low here is taken at the next
	// rising edge. The result of the previous command can be shown in that
	// same cycle, so the result is checked before the new command is noted.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n === 1'b1) begin
			if (done) shadow.check_result(result);
			if (start && !busy) shadow.note_command(item);
			if (done || (start && !busy)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks. The driver always returns just after a rising edge, so a
	// back-to-back command drives start high again in the step where the last
	// one was taken, with one nonblocking assignment to start in that step.
	// ------------------------------------------------------------------------
	task automatic send_command(ple_pkg::item_t cmd, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= cmd;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	// Hold the sender off until every awaited result beat has come back.
	task automatic drain_results();
		start <= 1'b0;
		while (shadow.awaited.size() != 0) @(posedge clk);
	endtask

	function automatic ple_pkg::item_t make_cmd(ple_pkg::op_t op, int pos,
		logic [ple_pkg::VALUE_W-1:0] val);
		ple_pkg::item_t c;
		c.func  = op;
		c.pos   = ple_pkg::POS_W'(pos);
		c.value = val;
		return c;
	endfunction

	// Number of idle cycles before a beat, for an idle chance of pct in 100.
	function automatic int draw_gap(int pct);
		int g;
		g = 0;
		while (g < MAX_GAP && $urandom_range(99) < pct) g++;
		return g;
	endfunction

	// Values lean on a small pool so that duplicates appear and locate has to
	// pick the first of several matches; the extremes show up now and then.
	function automatic logic [ple_pkg::VALUE_W-1:0] draw_value();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3:    return ple_pkg::VALUE_W'($urandom_range(3));
			default: return ple_pkg::VALUE_W'($urandom);
		endcase
	endfunction

	// One random command, mostly well formed for the current list length.
	// The list is grown toward full and shrunk toward empty in turns so that
	// long walks and the full case are reached often.
	function automatic ple_pkg::item_t draw_command();
		ple_pkg::item_t              c;
		int                          n;
		int                          w;
		int                          pos;
		ple_pkg::op_t                op;
		logic [ple_pkg::VALUE_W-1:0] val;
		n = shadow.fill;
		if (n == 0) growing = 1'b1;
		else if (n >= LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
		else if ($urandom_range(39) == 0) growing = !growing;
		w = $urandom_range(99);
		if (w < 20) op = ple_pkg::OP_LOCATE;
		else if (w < 40) op = ple_pkg::OP_GET;
		else if (w < (growing ? 85 : 55)) op = ple_pkg::OP_INSERT;
		else op = ple_pkg::OP_DELETE;
		if ($urandom_range(9) < 2) begin
			pos = $urandom_range(31);
		end else if (op == ple_pkg::OP_INSERT) begin
			pos = $urandom_range(n + 1, 1);
		end else if (n == 0) begin
			pos = $urandom_range(31);
		end else begin
			pos = $urandom_range(n, 1);
		end
		if (op == ple_pkg::OP_LOCATE && n > 0 && $urandom_range(9) < 6)
			val = shadow.slots[$urandom_range(n - 1)];
		else
			val = draw_value();
		c = make_cmd(op, pos, val);
		return c;
	endfunction

	initial begin
		int phase_pct [3];
		int pct;
		phase_pct = '{14, 69, 0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats on the empty list and on a short list.
		send_command(make_cmd(ple_pkg::OP_LOCATE, 0, '0), 0);   // locate, empty list
		send_command(make_cmd(ple_pkg::OP_GET, 1, '0), 0);      // get, empty list
		send_command(make_cmd(ple_pkg::OP_DELETE, 1, '0), 1);   // delete, empty list
		send_command(make_cmd(ple_pkg::OP_INSERT, 0, '1), 0);   // insert at position 0
		send_command(make_cmd(ple_pkg::OP_INSERT, 2, '1), 0);   // past count + 1
		send_command(make_cmd(ple_pkg::OP_INSERT, 1, '1), 2);
		send_command(make_cmd(ple_pkg::OP_INSERT, 1, '0), 0);   // in front
		send_command(make_cmd(ple_pkg::OP_INSERT, 3, 32'hA5A5_A5A5), 0); // at the tail
		send_command(make_cmd(ple_pkg::OP_INSERT, 2, '1), 0);   // duplicate value
		send_command(make_cmd(ple_pkg::OP_LOCATE, 31, '1), 0);  // first of two matches
		send_command(make_cmd(ple_pkg::OP_LOCATE, 5, 32'h1234_5678), 3); // no match
		send_command(make_cmd(ple_pkg::OP_GET, 0, '0), 0);
		send_command(make_cmd(ple_pkg::OP_GET, 31, '0), 0);
		send_command(make_cmd(ple_pkg::OP_GET, 4, '0), 0);
		send_command(make_cmd(ple_pkg::OP_GET, 5, '0), 0);      // one past count
		send_command(make_cmd(ple_pkg::OP_INSERT, 31, 32'h5A5A_5A5A), 0);
		send_command(make_cmd(ple_pkg::OP_DELETE, 0, '0), 0);
		send_command(make_cmd(ple_pkg::OP_DELETE, 5, '0), 0);
		send_command(make_cmd(ple_pkg::OP_DELETE, 2, '0), 1);   // from the middle
		send_command(make_cmd(ple_pkg::OP_DELETE, 3, '0), 0);   // the last entry
		send_command(make_cmd(ple_pkg::OP_LOCATE, 0, '0), 0);
		send_command(make_cmd(ple_pkg::OP_DELETE, 1, '0), 0);
		send_command(make_cmd(ple_pkg::OP_DELETE, 1, '0), 0);   // list now empty
		send_command(make_cmd(ple_pkg::OP_LOCATE, 0, '1), 0);
		drain_results();

		// Fill the list to capacity, then poke at the full list.
		while (shadow.fill < LIST_DEPTH)
			send_command(make_cmd(ple_pkg::OP_INSERT,
				$urandom_range(shadow.fill + 1, 1), draw_value()), draw_gap(14));
		send_command(make_cmd(ple_pkg::OP_INSERT, LIST_DEPTH + 1, '1), 0); // full, tail
		send_command(make_cmd(ple_pkg::OP_INSERT, 1, '0), 0);              // full, head
		send_command(make_cmd(ple_pkg::OP_INSERT, LIST_DEPTH + 2, '0), 0); // bad pos wins
		send_command(make_cmd(ple_pkg::OP_LOCATE, 0, shadow.slots[LIST_DEPTH-1]), 0);
		send_command(make_cmd(ple_pkg::OP_LOCATE, 0, 32'hDEAD_BEEF), 0);   // full walk
		send_command(make_cmd(ple_pkg::OP_GET, LIST_DEPTH, '0), 0);
		send_command(make_cmd(ple_pkg::OP_DELETE, 1, '0), 0);              // longest shift
		send_command(make_cmd(ple_pkg::OP_INSERT, 1, '1), 0);              // longest insert

		// Random phases: sender idles rarely, often, then never. The first ten
		// beats of every fifty go without gaps even in the idle phases.
		for (int ph = 0; ph < 3; ph++) begin
			drain_results();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pct = ((i % 50) < 10) ? 0 : phase_pct[ph];
				send_command(draw_command(), draw_gap(pct));
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
